// ===== rtl/core/prsq_pkg.sv =====
package prsq_pkg;

   localparam int SUM_W       = 40;
   localparam int VAL_W       = 30;
   localparam int IDX_W       = 11;
   localparam int ADDR_W      = 16;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   typedef enum logic {
      REQ_LOAD  = 1'b0,
      REQ_QUERY = 1'b1
   } req_kind_type;

   // One classified request passed from front to back.
   // Load: addr_a is the write index, wr_data the new prefix.
   // Query: addr_a = right-1, addr_b = left-2 (unused when lo_zero).
   typedef struct packed {
      logic              is_load;
      logic              err;
      logic              lo_zero;
      logic [ADDR_W-1:0] addr_a;
      logic [ADDR_W-1:0] addr_b;
      logic [SUM_W-1:0]  wr_data;
   } cmd_type;

endpackage

// ===== rtl/core/prsq_front.sv =====
module prsq_front
   import prsq_pkg::*;
#(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  req_kind_type     req_kind,
   input  logic [VAL_W-1:0] elem_value,
   input  logic             first_elem,
   input  logic [IDX_W-1:0] query_left,
   input  logic [IDX_W-1:0] query_right,
   input  logic             q_full,
   output logic             push,
   output cmd_type          cmd
);

   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int XW = (CW > IDX_W) ? CW : IDX_W;

   logic [CW-1:0]    count_ff, count_in;
   logic [SUM_W-1:0] total_ff, total_in;

   logic             accept;
   logic [CW-1:0]    base_count;
   logic [SUM_W-1:0] base_total;
   logic [SUM_W-1:0] sum;
   logic             has_room;
   logic             bad_bounds;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && !q_full;

   always_comb begin
      base_count = first_elem ? '0 : count_ff;
      base_total = first_elem ? '0 : total_ff;
      has_room   = base_count < CW'(TABLE_DEPTH);
      sum        = base_total + SUM_W'(elem_value);
      bad_bounds = (query_left == '0) || (query_left > query_right) ||
                   (XW'(query_right) > XW'(count_ff));

      count_in    = count_ff;
      total_in    = total_ff;
      push        = 1'b0;
      cmd.is_load = 1'b0;
      cmd.err     = bad_bounds;
      cmd.lo_zero = (query_left == IDX_W'(1));
      cmd.addr_a  = ADDR_W'(query_right - IDX_W'(1));
      cmd.addr_b  = ADDR_W'(query_left - IDX_W'(2));
      cmd.wr_data = sum;

      if (accept) begin
         if (req_kind == REQ_LOAD) begin
            count_in = base_count;
            total_in = base_total;
            if (has_room) begin
               count_in    = base_count + CW'(1);
               total_in    = sum;
               push        = 1'b1;
               cmd.is_load = 1'b1;
               cmd.err     = 1'b0;
               cmd.addr_a  = ADDR_W'(base_count);
            end
         end else begin
            push = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         total_ff <= '0;
      end else begin
         count_ff <= count_in;
         total_ff <= total_in;
      end
   end

endmodule

// ===== rtl/core/prsq_queue.sv =====
module prsq_queue
   import prsq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   output logic    empty,
   input  logic    pop,
   output cmd_type head
);

   cmd_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]   fill_ff, fill_in;

   assign full  = (fill_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign empty = (fill_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      fill_in = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - (QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         fill_ff <= fill_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== rtl/core/prsq_back.sv =====
module prsq_back
   import prsq_pkg::*;
#(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   input  cmd_type          head,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [SUM_W-1:0] rsp_sum,
   output logic             rsp_err
);

   localparam int AW = $clog2(TABLE_DEPTH);

   logic [SUM_W-1:0] mem [TABLE_DEPTH];
   logic [SUM_W-1:0] rd_hi_ff, rd_lo_ff;

   logic             pend_ff;
   logic             pend_err_ff;
   logic             pend_lo_zero_ff;
   logic             rsp_valid_ff;
   logic [SUM_W-1:0] rsp_sum_ff;
   logic             rsp_err_ff;

   logic             out_free;
   logic             pop_query;
   logic             pop_load;
   logic [SUM_W-1:0] diff;

   // A query may issue when its result slot is free by the time data returns.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign pop_load  = !q_empty && head.is_load;
   assign pop_query = !q_empty && !head.is_load && !pend_ff && out_free;
   assign pop       = pop_load || pop_query;

   assign diff = rd_hi_ff - (pend_lo_zero_ff ? '0 : rd_lo_ff);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_sum   = rsp_sum_ff;
   assign rsp_err   = rsp_err_ff;

   always_ff @(posedge clock) begin
      if (pop_load) begin
         mem[head.addr_a[AW-1:0]] <= head.wr_data;
      end
      rd_hi_ff <= mem[head.addr_a[AW-1:0]];
      rd_lo_ff <= mem[head.addr_b[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff <= pop_query;
         if (pend_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop_query) begin
         pend_err_ff     <= head.err;
         pend_lo_zero_ff <= head.lo_zero;
      end
      if (pend_ff) begin
         rsp_sum_ff <= pend_err_ff ? '0 : diff;
         rsp_err_ff <= pend_err_ff;
      end
   end

endmodule

// ===== rtl/core/prefix_sum_range_query_unit.sv =====
// Prefix-sum range query unit. Load requests (tuser = 0) append one element to a
// table of running 40-bit prefix sums; tdata first_elem restarts the table, and
// loads past TABLE_DEPTH entries are dropped. Query requests (tuser = 1) return
// sum(left..right), 1-indexed and inclusive, or range_error with a zero sum when
// left is 0, left > right or right is beyond the loaded count. Loads give no
// response. The front end classifies a request in its accept cycle and keeps
// count and total, so requests are taken every cycle while the four-entry queue
// has room. The back end drains one load per cycle (one table write) and one query
// at a time, only when the result slot is free (registered dual read of the table,
// then subtract), bounding sustained query throughput. The table needs no clearing pass.
module prefix_sum_range_query_unit
   import prsq_pkg::*;
#(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,  // elem_value[29:0], first_elem, query_left, query_right
   input  logic        req_tuser,  // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // range_sum
   output logic        rsp_tuser   // range_error
);

   logic    push;
   logic    pop;
   logic    q_full;
   logic    q_empty;
   cmd_type push_cmd;
   cmd_type head;

   prsq_front #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_kind_type'(req_tuser)),
      .elem_value (req_tdata[29:0]),
      .first_elem (req_tdata[30]),
      .query_left (req_tdata[41:31]),
      .query_right(req_tdata[52:42]),
      .q_full     (q_full),
      .push       (push),
      .cmd        (push_cmd)
   );

   prsq_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_cmd(push_cmd),
      .full    (q_full),
      .empty   (q_empty),
      .pop     (pop),
      .head    (head)
   );

   prsq_back #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .head     (head),
      .pop      (pop),
      .rsp_valid(rsp_tvalid),
      .rsp_ready(rsp_tready),
      .rsp_sum  (rsp_tdata),
      .rsp_err  (rsp_tuser)
   );

endmodule

// ===== bench/prefix_sum_range_query_unit_test.sv =====
`timescale 1ns / 1ps

module prefix_sum_range_query_unit_test;
   import prsq_pkg::*;

   localparam int TABLE_DEPTH = 1024;
   localparam int ITEM_GOAL   = 1500;
   localparam int CYCLE_LIMIT = 300000;
   localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};
   localparam logic [IDX_W-1:0] IDX_MAX = {IDX_W{1'b1}};

   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic             err;
   } range_result_type;

   class range_sum_scoreboard;
      logic [SUM_W-1:0] prefix_table [TABLE_DEPTH];
      logic [SUM_W-1:0] total;
      int unsigned      loaded;
      range_result_type expected_sums [$];
      int failures, loads, dropped_loads, queries, bad_queries, checked;

      function new();
         total         = '0;
         loaded        = 0;
         failures      = 0;
         loads         = 0;
         dropped_loads = 0;
         queries       = 0;
         bad_queries   = 0;
         checked       = 0;
      endfunction

      function void note_request(req_kind_type kind, logic [55:0] data);
         logic [VAL_W-1:0] value;
         logic             restart;
         logic [IDX_W-1:0] lo_idx, hi_idx;
         logic [SUM_W-1:0] hi_sum, lo_sum;
         range_result_type res;
         value   = data[VAL_W-1:0];
         restart = data[VAL_W];
         lo_idx  = data[VAL_W+1 +: IDX_W];
         hi_idx  = data[VAL_W+1+IDX_W +: IDX_W];
         if (kind == REQ_LOAD) begin
            loads++;
            if (restart) begin
               loaded = 0;
               total  = '0;
            end
            if (loaded < TABLE_DEPTH) begin
               total = total + SUM_W'(value);
               prefix_table[loaded] = total;
               loaded++;
            end else begin
               dropped_loads++;
            end
         end else begin
            queries++;
            if (lo_idx == 0 || lo_idx > hi_idx || hi_idx > loaded) begin
               bad_queries++;
               res.sum = '0;
               res.err = 1'b1;
            end else begin
               hi_sum  = prefix_table[hi_idx - 1];
               lo_sum  = (lo_idx > 1) ? prefix_table[lo_idx - 2] : '0;
               res.sum = hi_sum - lo_sum;
               res.err = 1'b0;
            end
            expected_sums.push_back(res);
         end
      endfunction

      function void check_response(logic [SUM_W-1:0] sum, logic err);
         range_result_type exp_res;
         if (expected_sums.size() == 0) begin
            $display("%0t: unexpected response, expected none, got sum %0d err %0b",
                     $time, sum, err);
            failures++;
         end else begin
            exp_res = expected_sums.pop_front();
            checked++;
            if (sum !== exp_res.sum) begin
               $display("%0t: range_sum mismatch, expected %0d, got %0d",
                        $time, exp_res.sum, sum);
               failures++;
            end
            if (err !== exp_res.err) begin
               $display("%0t: range_error mismatch, expected %0b, got %0b",
                        $time, exp_res.err, err);
               failures++;
            end
         end
      endfunction

      function int pending();
         return expected_sums.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [55:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic        rsp_tuser;

   range_sum_scoreboard sb = new();

   int unsigned fill_level;
   int          counted;
   int          burst_left;
   bit          steady;
   bit          hold_request;
   int          cycles;

   prefix_sum_range_query_unit #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            sb.note_request(req_kind_type'(req_tuser), req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            sb.check_response(rsp_tdata, rsp_tuser);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d responses outstanding", cycles, sb.pending());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // response side: long hold on request, otherwise a randomly chosen stall pattern
   initial begin
      int hold_left, mode, mode_left, phase;
      bit hold_done;
      hold_left  = 0;
      mode       = 0;
      mode_left  = 0;
      phase      = 0;
      hold_done  = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 3);
               mode_left = $urandom_range(16, 128);
            end
            mode_left--;
            phase++;
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= $urandom_range(0, 1);
               2: rsp_tready <= (phase % 4) != 0;
               default: rsp_tready <= (phase % 5) == 0;
            endcase
         end
      end
   end

   task automatic pace();
      int gap;
      if (!steady) begin
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            gap = $urandom_range(1, 8);
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
            burst_left = $urandom_range(0, 15);
         end
      end
   endtask

   task automatic send_request(input req_kind_type kind, input logic [VAL_W-1:0] value,
                               input logic restart, input logic [IDX_W-1:0] lo_idx,
                               input logic [IDX_W-1:0] hi_idx);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {3'b000, hi_idx, lo_idx, restart, value};
      do @(posedge clock); while (!req_tready);
      if (kind == REQ_LOAD) begin
         if (restart) begin
            fill_level = 1;
            counted++;
         end else if (fill_level < TABLE_DEPTH) begin
            fill_level++;
            counted++;
         end
      end else begin
         counted++;
      end
      pace();
   endtask

   task automatic send_load(input logic [VAL_W-1:0] value, input logic restart);
      send_request(REQ_LOAD, value, restart, IDX_W'($urandom), IDX_W'($urandom));
   endtask

   task automatic send_query(input logic [IDX_W-1:0] lo_idx, input logic [IDX_W-1:0] hi_idx);
      send_request(REQ_QUERY, VAL_W'($urandom), 1'($urandom), lo_idx, hi_idx);
   endtask

   task automatic random_load(input logic restart);
      int pick;
      logic [VAL_W-1:0] value;
      pick = $urandom_range(0, 9);
      if (pick == 0) value = VAL_MAX;
      else if (pick == 1) value = VAL_W'($urandom_range(0, 15));
      else value = VAL_W'($urandom);
      send_load(value, restart);
   endtask

   task automatic random_query();
      int pick;
      logic [IDX_W-1:0] lo_idx, hi_idx;
      pick = $urandom_range(0, 99);
      if (fill_level == 0 || pick >= 85) begin
         case ($urandom_range(0, 3))
            0: begin
               lo_idx = '0;
               hi_idx = IDX_W'($urandom);
            end
            1: begin
               hi_idx = IDX_W'($urandom_range(1, 2046));
               lo_idx = IDX_W'($urandom_range(hi_idx + 1, 2047));
            end
            2: begin
               hi_idx = IDX_W'($urandom_range(fill_level + 1, 2047));
               lo_idx = IDX_W'($urandom_range(1, hi_idx));
            end
            default: begin
               lo_idx = IDX_W'($urandom);
               hi_idx = IDX_W'($urandom);
            end
         endcase
      end else if (pick < 10) begin
         lo_idx = IDX_W'(1);
         hi_idx = IDX_W'(fill_level);
      end else begin
         hi_idx = IDX_W'($urandom_range(1, fill_level));
         lo_idx = IDX_W'($urandom_range(1, hi_idx));
      end
      send_query(lo_idx, hi_idx);
   endtask

   task automatic run_sequence(input int n_loads, input int n_queries, input bit restart);
      int  loads_left, queries_left;
      bit  need_restart;
      loads_left   = n_loads;
      queries_left = n_queries;
      need_restart = restart;
      while (loads_left + queries_left > 0) begin
         if (loads_left > 0 && (queries_left == 0 || need_restart
                                || $urandom_range(0, 2) != 0)) begin
            random_load(need_restart);
            need_restart = 1'b0;
            loads_left--;
         end else begin
            random_query();
            queries_left--;
         end
      end
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   initial begin
      int seq;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = REQ_LOAD;
      reset        = 1'b1;
      fill_level   = 0;
      counted      = 0;
      burst_left   = 0;
      steady       = 1'b1;
      hold_request = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, field extremes, bad bounds, restart mid-table
      send_query(1, 1);
      send_request(REQ_LOAD, VAL_MAX, 1'b1, IDX_MAX, IDX_MAX);
      send_load('0, 1'b0);
      send_load(30'h2AAAAAAA, 1'b0);
      send_load(30'h15555555, 1'b0);
      send_load(VAL_MAX, 1'b0);
      send_query(1, 1);
      send_query(1, 5);
      send_query(2, 5);
      send_query(5, 5);
      send_query(3, 2);
      send_query(0, 3);
      send_query(1, 6);
      send_request(REQ_QUERY, VAL_MAX, 1'b1, IDX_MAX, IDX_MAX);
      send_request(REQ_QUERY, '0, 1'b0, '0, '0);
      send_load(30'd7, 1'b1);
      send_query(1, 2);
      send_query(1, 1);
      send_load(30'd1, 1'b0);
      send_query(2, 2);
      send_query(IDX_W'(TABLE_DEPTH), IDX_W'(TABLE_DEPTH));
      wait_for_results();

      seq = 0;
      while (counted < ITEM_GOAL + 21) begin
         steady = ($urandom_range(0, 3) == 0);
         if (seq == 1) begin
            run_sequence(30, 5, 1'b1);
            hold_request = 1'b1;
            steady       = 1'b1;
            repeat (40) random_query();
         end else if (seq == 3) begin
            // fill past the table depth, then query the full table
            run_sequence(TABLE_DEPTH + 6, 0, 1'b1);
            send_query(1, IDX_W'(TABLE_DEPTH));
            send_query(IDX_W'(TABLE_DEPTH), IDX_W'(TABLE_DEPTH));
            send_query(1, IDX_W'(TABLE_DEPTH + 1));
            run_sequence(3, 60, 1'b0);
         end else if (seq == 6) begin
            wait_for_results();
            run_sequence($urandom_range(1, 40), $urandom_range(5, 40), 1'b1);
         end else begin
            run_sequence($urandom_range(1, 40), $urandom_range(5, 40),
                         $urandom_range(0, 9) != 0);
         end
         seq++;
      end

      wait_for_results();
      repeat (16) @(posedge clock);
      $display("Loads: %0d (%0d dropped on a full table), queries: %0d (%0d out of bounds)",
               sb.loads, sb.dropped_loads, sb.queries, sb.bad_queries);
      $display("Responses checked: %0d, mismatches: %0d", sb.checked, sb.failures);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/prsq_pkg.sv
rtl/core/prsq_front.sv
rtl/core/prsq_queue.sv
rtl/core/prsq_back.sv
rtl/core/prefix_sum_range_query_unit.sv
bench/prefix_sum_range_query_unit_test.sv
